@@ rtl/rpms_pkg.sv @@
// Package for the randomized Prim maze step block: sizes, state and command codes,
// neighbour list types and the cell helper functions.
// No dependencies.
package rpms_pkg;

  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int CELL_W   = ROW_W + COL_W;
  localparam int MAX_DIM  = 64;
  localparam int DIM_W    = 7;
  localparam int FR_DEPTH = 4096;
  localparam int FR_AW    = 12;
  localparam int SIZE_W   = 13;
  localparam int RAND_W   = 31;
  localparam int BIT_W    = 5;
  localparam int CNT_W    = 3;
  localparam int NB_MAX   = 4;
  localparam int OPEN_LIMIT = 2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_OPEN0,
    ST_OPEN1,
    ST_START_PUSH,
    ST_MOD,
    ST_PICK_RD,
    ST_PICK_WAIT,
    ST_NB_CALC,
    ST_CNT_RD,
    ST_CNT_WAIT,
    ST_SHIFT,
    ST_OPEN_CELL,
    ST_PUSH_RD,
    ST_PUSH_WAIT,
    ST_RESULT
  } state_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_HEIGHT = 1'b0,
    REG_WIDTH  = 1'b1
  } reg_e;

  typedef struct packed {
    logic              ok;
    logic [CELL_W-1:0] idx;
  } nb_t;

  typedef nb_t [NB_MAX-1:0] nbl_t;

  // Clamp a grid dimension register to [2, MAX_DIM]
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(2))              res = DIM_W'(2);
    else if (v > DIM_W'(MAX_DIM))   res = DIM_W'(MAX_DIM);
    else                            res = v;
    return res;
  endfunction

  // Cells queued by a start command, in queue order
  function automatic logic [CELL_W-1:0] start_cell(input logic [1:0] i,
                                                   input logic [DIM_W-1:0] h,
                                                   input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0]  hm1, hm2, wm1, wm2;
    logic [CELL_W-1:0] res;
    hm1 = h - DIM_W'(1);
    hm2 = h - DIM_W'(2);
    wm1 = w - DIM_W'(1);
    wm2 = w - DIM_W'(2);
    unique case (i)
      2'd0:    res = {ROW_W'(0), COL_W'(1)};
      2'd1:    res = {ROW_W'(1), COL_W'(0)};
      2'd2:    res = {hm1[ROW_W-1:0], wm2[COL_W-1:0]};
      default: res = {hm2[ROW_W-1:0], wm1[COL_W-1:0]};
    endcase
    return res;
  endfunction

  // Neighbour list of a cell by position class; coordinates are 8-bit two's
  // complement, so a value is inside storage when its top two bits are zero.
  function automatic nbl_t nb_list(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                   input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] w);
    nbl_t            res;
    logic [7:0]      ri, ci, hm1, hm2, wm1, wm2;
    logic [3:0][7:0] rr, cc;
    logic [3:0]      use_e;
    ri  = {2'b00, r};
    ci  = {2'b00, c};
    hm1 = {1'b0, h} - 8'd1;
    hm2 = {1'b0, h} - 8'd2;
    wm1 = {1'b0, w} - 8'd1;
    wm2 = {1'b0, w} - 8'd2;
    rr    = '0;
    cc    = '0;
    use_e = 4'b0011;
    priority if (ri == 8'd0 && ci == 8'd0) begin
      rr[0] = 8'd0; cc[0] = 8'd1; rr[1] = 8'd1; cc[1] = 8'd0;
    end else if (ri == 8'd0 && ci == wm1) begin
      rr[0] = 8'd0; cc[0] = wm2; rr[1] = 8'd1; cc[1] = wm1;
    end else if (ri == hm1 && ci == 8'd0) begin
      rr[0] = hm2; cc[0] = 8'd0; rr[1] = hm1; cc[1] = 8'd1;
    end else if (ri == hm1 && ci == wm1) begin
      rr[0] = hm1; cc[0] = wm2; rr[1] = hm2; cc[1] = wm1;
    end else if (ri == 8'd0) begin
      use_e = 4'b0111;
      rr[0] = 8'd0; cc[0] = ci - 8'd1; rr[1] = 8'd0; cc[1] = ci + 8'd1;
      rr[2] = 8'd1; cc[2] = ci;
    end else if (ci == 8'd0) begin
      use_e = 4'b0111;
      rr[0] = ri - 8'd1; cc[0] = 8'd0; rr[1] = ri + 8'd1; cc[1] = 8'd0;
      rr[2] = ri; cc[2] = 8'd1;
    end else if (ri == hm1) begin
      use_e = 4'b0111;
      rr[0] = hm1; cc[0] = ci - 8'd1; rr[1] = hm1; cc[1] = ci + 8'd1;
      rr[2] = hm2; cc[2] = ci;
    end else if (ci == wm1) begin
      use_e = 4'b0111;
      rr[0] = ri - 8'd1; cc[0] = wm1; rr[1] = ri + 8'd1; cc[1] = wm1;
      rr[2] = ri; cc[2] = wm2;
    end else begin
      use_e = 4'b1111;
      rr[0] = ri - 8'd1; cc[0] = ci; rr[1] = ri + 8'd1; cc[1] = ci;
      rr[2] = ri; cc[2] = ci - 8'd1; rr[3] = ri; cc[3] = ci + 8'd1;
    end
    for (int i = 0; i < NB_MAX; i++) begin
      res[i].ok  = use_e[i] && (rr[i][7:6] == 2'b00) && (cc[i][7:6] == 2'b00);
      res[i].idx = {rr[i][ROW_W-1:0], cc[i][COL_W-1:0]};
    end
    return res;
  endfunction

endpackage

@@ rtl/randomized_prim_maze_step.sv @@
// Top level of the randomized Prim maze step block: sequencer, divider,
// cell and frontier memories. Depends on rpms_pkg.
//
// Channel   Dir  Payload
// s_axis    in   tuser = cmd, tdata[30:0] = random_value
// m_axis    out  tdata = row, col, cleared, open_neighbours, frontier_count, done_res
// cfg       in   cfg_idx_i 0 = grid_height, 1 = grid_width, cfg_wdata_i[6:0]
//
// Order of work after the input transfer: start runs a clearing sweep over all 4096 cells, opens two
// corners, queues the four start entries and gives the result. Step runs the restoring modulo, fetches
// the pick, counts open neighbours (a read per neighbour slot), shifts later entries down, opens the cell
// and queues its neighbours when it is opened, and gives the result.
// Empty frontier: only the result. Reset empties the frontier; each start clears the cells.
// A result waits in ST_RESULT while the previous one is not taken; input only when idle.
module randomized_prim_maze_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,   // [30:0] random_value
  input  logic                       s_axis_tuser,   // [0] cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [5:0] row, [11:6] col, [12] cleared, [15:13] open_neighbours,
  // [28:16] frontier_count, [29] done_res
  output logic [31:0]                m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rpms_pkg::DIM_W-1:0] cfg_wdata_i
);
  import rpms_pkg::*;

  state_e              state_q, state_d;
  logic [DIM_W-1:0]    height_q, width_q, h, w;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [FR_AW-1:0]    rem_q, rem_d;
  logic [RAND_W-1:0]   rnd_q, rnd_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  nbl_t                nbl_q, nbl_d;
  logic [1:0]          i_q, i_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                clr_q, clr_d;
  logic [SIZE_W-1:0]   sh_q, sh_d;
  logic                wp_q, wp_d;
  logic [FR_AW-1:0]    wa_q, wa_d;
  logic [CELL_W-1:0]   sweep_q, sweep_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_data_q, out_data_d;
  logic                in_xfer, out_free;
  logic [SIZE_W:0]     mod_t;
  logic [DIM_W-1:0]    hm1, wm1;

  // Memories and their ports
  logic [CELL_W-1:0]   fr_mem [FR_DEPTH];
  logic                open_mem [MAX_DIM*MAX_DIM];
  logic                seen_mem [MAX_DIM*MAX_DIM];
  logic                fr_we, open_we, open_wdata, seen_we, seen_wdata;
  logic [FR_AW-1:0]    fr_waddr, fr_raddr;
  logic [CELL_W-1:0]   fr_wdata, fr_rd_q;
  logic [CELL_W-1:0]   open_waddr, seen_waddr, cell_raddr;
  logic                open_rd_q, seen_rd_q;

  assign h        = eff_dim(height_q);
  assign w        = eff_dim(width_q);
  assign hm1      = h - DIM_W'(1);
  assign wm1      = w - DIM_W'(1);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign mod_t    = {1'b0, rem_q, rnd_q[RAND_W-1]};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cmd_e'(s_axis_tuser) == CMD_START) state_d = ST_CLR;
          else if (size_q == '0)                 state_d = ST_RESULT;
          else                                   state_d = ST_MOD;
        end
      end
      ST_CLR:        if (sweep_q == '1) state_d = ST_OPEN0;
      ST_OPEN0:      state_d = ST_OPEN1;
      ST_OPEN1:      state_d = ST_START_PUSH;
      ST_START_PUSH: if (i_q == 2'd3) state_d = ST_RESULT;
      ST_MOD:        if (bit_q == '0) state_d = ST_PICK_RD;
      ST_PICK_RD:    state_d = ST_PICK_WAIT;
      ST_PICK_WAIT:  state_d = ST_NB_CALC;
      ST_NB_CALC:    state_d = ST_CNT_RD;
      ST_CNT_RD:     state_d = ST_CNT_WAIT;
      ST_CNT_WAIT:   state_d = (i_q == 2'd3) ? ST_SHIFT : ST_CNT_RD;
      ST_SHIFT: begin
        if (!(sh_q < size_q) && !wp_q) begin
          state_d = (cnt_q < CNT_W'(OPEN_LIMIT)) ? ST_OPEN_CELL : ST_RESULT;
        end
      end
      ST_OPEN_CELL:  state_d = ST_PUSH_RD;
      ST_PUSH_RD:    state_d = ST_PUSH_WAIT;
      ST_PUSH_WAIT:  state_d = (i_q == 2'd3) ? ST_RESULT : ST_PUSH_RD;
      ST_RESULT:     if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Datapath control and memory ports
  always_comb begin
    size_d      = size_q;
    rem_d       = rem_q;
    rnd_d       = rnd_q;
    bit_d       = bit_q;
    cell_d      = cell_q;
    nbl_d       = nbl_q;
    i_d         = i_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    sh_d        = sh_q;
    wp_d        = wp_q;
    wa_d        = wa_q;
    sweep_d     = sweep_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    fr_we       = 1'b0;
    fr_waddr    = size_q[FR_AW-1:0];
    fr_wdata    = fr_rd_q;
    fr_raddr    = sh_q[FR_AW-1:0];
    open_we     = 1'b0;
    open_waddr  = cell_q;
    open_wdata  = 1'b1;
    seen_we     = 1'b0;
    seen_waddr  = nbl_q[i_q].idx;
    seen_wdata  = 1'b1;
    cell_raddr  = nbl_q[i_q].idx;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          rnd_d   = s_axis_tdata[RAND_W-1:0];
          cell_d  = '0;
          cnt_d   = '0;
          clr_d   = 1'b0;
          rem_d   = '0;
          bit_d   = BIT_W'(RAND_W - 1);
          sweep_d = '0;
          i_d     = '0;
          if (cmd_e'(s_axis_tuser) == CMD_START) size_d = '0;
        end
      end
      // Clear both cell memories, one entry a cycle
      ST_CLR: begin
        open_we    = 1'b1;
        open_waddr = sweep_q;
        open_wdata = 1'b0;
        seen_we    = 1'b1;
        seen_waddr = sweep_q;
        seen_wdata = 1'b0;
        sweep_d    = sweep_q + CELL_W'(1);
      end
      ST_OPEN0: begin
        open_we    = 1'b1;
        open_waddr = '0;
      end
      ST_OPEN1: begin
        open_we    = 1'b1;
        open_waddr = {hm1[ROW_W-1:0], wm1[COL_W-1:0]};
      end
      // Start entries are queued without a seen check
      ST_START_PUSH: begin
        fr_we      = 1'b1;
        fr_wdata   = start_cell(i_q, h, w);
        seen_we    = 1'b1;
        seen_waddr = start_cell(i_q, h, w);
        size_d     = size_q + SIZE_W'(1);
        i_d        = i_q + 2'd1;
      end
      // Restoring modulo, one dividend bit per cycle
      ST_MOD: begin
        if (mod_t >= {1'b0, size_q}) rem_d = FR_AW'(mod_t - {1'b0, size_q});
        else                         rem_d = mod_t[FR_AW-1:0];
        rnd_d = rnd_q << 1;
        bit_d = bit_q - BIT_W'(1);
      end
      ST_PICK_RD:   fr_raddr = rem_q;
      ST_PICK_WAIT: cell_d   = fr_rd_q;
      ST_NB_CALC: begin
        nbl_d = nb_list(cell_q[CELL_W-1:COL_W], cell_q[COL_W-1:0], h, w);
        i_d   = '0;
      end
      ST_CNT_RD: ;
      ST_CNT_WAIT: begin
        if (nbl_q[i_q].ok && open_rd_q) cnt_d = cnt_q + CNT_W'(1);
        i_d  = i_q + 2'd1;
        sh_d = {1'b0, rem_q} + SIZE_W'(1);
        wp_d = 1'b0;
      end
      // Move later entries down one place: read ahead, write one behind
      ST_SHIFT: begin
        if (sh_q < size_q) begin
          wp_d = 1'b1;
          wa_d = sh_q[FR_AW-1:0] - FR_AW'(1);
          sh_d = sh_q + SIZE_W'(1);
        end else begin
          wp_d = 1'b0;
        end
        if (wp_q) begin
          fr_we    = 1'b1;
          fr_waddr = wa_q;
        end
        if (!(sh_q < size_q) && !wp_q) begin
          size_d = size_q - SIZE_W'(1);
          i_d    = '0;
        end
      end
      ST_OPEN_CELL: begin
        open_we = 1'b1;
        clr_d   = 1'b1;
      end
      ST_PUSH_RD: ;
      ST_PUSH_WAIT: begin
        if (nbl_q[i_q].ok && !seen_rd_q && (size_q < SIZE_W'(FR_DEPTH))) begin
          fr_we    = 1'b1;
          fr_wdata = nbl_q[i_q].idx;
          seen_we  = 1'b1;
          size_d   = size_q + SIZE_W'(1);
        end
        i_d = i_q + 2'd1;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, (size_q == '0), size_q, cnt_q, clr_q,
                         cell_q[COL_W-1:0], cell_q[CELL_W-1:COL_W]};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= '0;
      out_valid_q <= 1'b0;
      height_q    <= DIM_W'(MAX_DIM);
      width_q     <= DIM_W'(MAX_DIM);
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_HEIGHT: height_q <= cfg_wdata_i;
          REG_WIDTH:  width_q  <= cfg_wdata_i;
          default:    ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    rnd_q      <= rnd_d;
    bit_q      <= bit_d;
    cell_q     <= cell_d;
    nbl_q      <= nbl_d;
    i_q        <= i_d;
    cnt_q      <= cnt_d;
    clr_q      <= clr_d;
    sh_q       <= sh_d;
    wp_q       <= wp_d;
    wa_q       <= wa_d;
    sweep_q    <= sweep_d;
    out_data_q <= out_data_d;
  end

  // Frontier memory
  always_ff @(posedge clk_i) begin
    if (fr_we) fr_mem[fr_waddr] <= fr_wdata;
    fr_rd_q <= fr_mem[fr_raddr];
  end

  // Cell open memory
  always_ff @(posedge clk_i) begin
    if (open_we) open_mem[open_waddr] <= open_wdata;
    open_rd_q <= open_mem[cell_raddr];
  end

  // Cell seen memory
  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
    seen_rd_q <= seen_mem[cell_raddr];
  end

`ifndef NO_ASSERTIONS
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= SIZE_W'(FR_DEPTH))
    else $error("frontier size beyond depth");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK_RD) |-> ({1'b0, rem_q} < size_q))
    else $error("picked index outside frontier");

  a_empty_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser && size_q == '0) |=> (state_q == ST_RESULT))
    else $error("step on empty frontier did not finish at once");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (cnt_q <= CNT_W'(NB_MAX)))
    else $error("open neighbour count too large");

  a_start_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START_PUSH && i_q == 2'd3) |=> (size_q == SIZE_W'(4)))
    else $error("start did not queue four entries");
`endif

endmodule

@@ dv/randomized_prim_maze_step_tb.sv @@
// Testbench for randomized_prim_maze_step: drives start and step commands over the
// input stream and checks each result against a behavioral maze predictor.
// Depends on rpms_pkg and the block's RTL.
module randomized_prim_maze_step_tb;
  import rpms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              done_res;
    logic [12:0]       frontier_count;
    logic [2:0]        open_neighbours;
    logic              cleared;
    logic [5:0]        col;
    logic [5:0]        row;
  } maze_res_t;

  typedef struct {
    cmd_e              cmd;
    logic [RAND_W-1:0] rnd;
  } maze_cmd_t;

  logic              clk_i, rst_ni;
  logic              s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [31:0]       s_axis_tdata;
  logic              m_axis_tvalid, m_axis_tready;
  logic [31:0]       m_axis_tdata;
  logic              cfg_we_i, cfg_idx_i;
  logic [DIM_W-1:0]  cfg_wdata_i;

  randomized_prim_maze_step DUT (.*);

  // Predictor state
  bit          open_q [MAX_DIM*MAX_DIM];
  bit          seen_q [MAX_DIM*MAX_DIM];
  int          front_q [$];
  int          height_q, width_q;
  maze_res_t   expected_q [$];
  maze_cmd_t   pending_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          sent = 0;
  bit          stim_done;

  function automatic int clamp_dim(int v);
    return v < 2 ? 2 : (v > MAX_DIM ? MAX_DIM : v);
  endfunction

  function automatic int cell_id(int r, int c);
    if (r < 0 || c < 0 || r >= MAX_DIM || c >= MAX_DIM) return -1;
    return r * MAX_DIM + c;
  endfunction

  function automatic void enqueue_cell(int id, bit check_seen);
    if (id < 0) return;
    if (check_seen && seen_q[id]) return;
    if (front_q.size() >= FR_DEPTH) return;
    front_q.insert(front_q.size(), id);
    seen_q[id] = 1;
  endfunction

  function automatic maze_res_t predict_maze(maze_cmd_t it);
    maze_res_t res;
    int h, w, r, c, pick, cnt, n;
    int nb [4];
    h = clamp_dim(height_q);
    w = clamp_dim(width_q);
    res = '0;
    if (it.cmd == CMD_START) begin
      foreach (open_q[i]) begin open_q[i] = 0; seen_q[i] = 0; end
      front_q.delete();
      open_q[0] = 1;
      open_q[(h-1)*MAX_DIM + w-1] = 1;
      enqueue_cell(cell_id(0, 1), 0);
      enqueue_cell(cell_id(1, 0), 0);
      enqueue_cell(cell_id(h-1, w-2), 0);
      enqueue_cell(cell_id(h-2, w-1), 0);
    end else if (front_q.size() != 0) begin
      pick = int'(longint'(it.rnd) % front_q.size());
      r = front_q[pick] / MAX_DIM;
      c = front_q[pick] % MAX_DIM;
      n = 2;
      if (r == 0 && c == 0) begin nb[0] = cell_id(0,1); nb[1] = cell_id(1,0); end
      else if (r == 0 && c == w-1) begin nb[0] = cell_id(0,w-2); nb[1] = cell_id(1,w-1); end
      else if (r == h-1 && c == 0) begin nb[0] = cell_id(h-2,0); nb[1] = cell_id(h-1,1); end
      else if (r == h-1 && c == w-1) begin
        nb[0] = cell_id(h-1,w-2); nb[1] = cell_id(h-2,w-1);
      end else if (r == 0) begin
        n = 3; nb[0] = cell_id(0,c-1); nb[1] = cell_id(0,c+1); nb[2] = cell_id(1,c);
      end else if (c == 0) begin
        n = 3; nb[0] = cell_id(r-1,0); nb[1] = cell_id(r+1,0); nb[2] = cell_id(r,1);
      end else if (r == h-1) begin
        n = 3; nb[0] = cell_id(h-1,c-1); nb[1] = cell_id(h-1,c+1); nb[2] = cell_id(h-2,c);
      end else if (c == w-1) begin
        n = 3; nb[0] = cell_id(r-1,w-1); nb[1] = cell_id(r+1,w-1); nb[2] = cell_id(r,w-2);
      end else begin
        n = 4; nb[0] = cell_id(r-1,c); nb[1] = cell_id(r+1,c);
        nb[2] = cell_id(r,c-1); nb[3] = cell_id(r,c+1);
      end
      cnt = 0;
      for (int i = 0; i < n; i++) if (nb[i] >= 0 && open_q[nb[i]]) cnt++;
      front_q.delete(pick);
      if (cnt < OPEN_LIMIT) begin
        res.cleared = 1;
        open_q[r*MAX_DIM + c] = 1;
        for (int i = 0; i < n; i++) enqueue_cell(nb[i], 1);
      end
      res.row = r[5:0];
      res.col = c[5:0];
      res.open_neighbours = cnt[2:0];
    end
    res.frontier_count = 13'(front_q.size());
    res.done_res = (front_q.size() == 0);
    return res;
  endfunction

  // Clock and cycle limit
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Driver: bursts with random gaps; prediction at transfer
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tuser  <= CMD_START;
      s_axis_tdata  <= '0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.insert(expected_q.size(),
                          predict_maze('{cmd_e'(s_axis_tuser), s_axis_tdata[30:0]}));
        sent <= sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          s_axis_tvalid <= 0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          maze_cmd_t it;
          it = pending_q.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tuser  <= it.cmd;
          s_axis_tdata  <= {1'b0, it.rnd};
          if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver stall pattern and result checker
  logic [7:0] stall_pat;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
      stall_pat <= 8'b1011_0111;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          maze_res_t e, a;
          e = expected_q.pop_front();
          a = m_axis_tdata[29:0];
          if (a !== e || m_axis_tdata[31:30] !== 2'b0) begin
            $display("%0t: result mismatch expected %h actual %h", $realtime, e, m_axis_tdata);
            errors <= errors + 1;
          end
        end
      end
      stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5]};
      m_axis_tready <= stim_done ? 1'b1 : (($urandom_range(0, 9) == 0) ? 1'b1 : stall_pat[0]);
    end
  end

  task automatic write_dim(reg_e idx, int v);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= v[DIM_W-1:0];
    if (idx == REG_HEIGHT) height_q = v & 127; else width_q = v & 127;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_item(cmd_e cmd, logic [RAND_W-1:0] rnd);
    pending_q.insert(pending_q.size(), '{cmd, rnd});
  endtask

  // Phases: most set a grid, start a maze, then step through it
  initial begin
    int h, w, nsteps;
    height_q = 64; width_q = 64;
    stim_done = 0;
    cfg_we_i = 0; cfg_idx_i = REG_HEIGHT; cfg_wdata_i = '0;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    // Step on empty frontier right after reset, then a full-size start
    add_item(CMD_STEP, 31'h7FFF_FFFF);
    add_item(CMD_START, 31'h5555_5555);
    add_item(CMD_STEP, 31'h0);
    add_item(CMD_STEP, 31'h7FFF_FFFF);
    add_item(CMD_STEP, 31'h2AAA_AAAA);
    wait_drained();
    // Out-of-range and smallest grids, duplicate start entries
    write_dim(REG_HEIGHT, 0); write_dim(REG_WIDTH, 127);
    add_item(CMD_START, '0);
    repeat (6) add_item(CMD_STEP, RAND_W'($urandom()));
    wait_drained();
    write_dim(REG_HEIGHT, 2); write_dim(REG_WIDTH, 2);
    add_item(CMD_START, '0);
    repeat (7) add_item(CMD_STEP, RAND_W'($urandom()));
    wait_drained();
    // Shrink grid mid-maze so neighbours fall outside storage
    write_dim(REG_HEIGHT, 64); write_dim(REG_WIDTH, 64);
    add_item(CMD_START, '0);
    repeat (3) add_item(CMD_STEP, RAND_W'($urandom()));
    wait_drained();
    write_dim(REG_HEIGHT, 3); write_dim(REG_WIDTH, 1);
    repeat (3) add_item(CMD_STEP, RAND_W'($urandom()));
    wait_drained();
    // Random phases on small grids, stepped mostly to completion
    while (sent < 140) begin
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 6);
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 6);
      write_dim(REG_HEIGHT, h); write_dim(REG_WIDTH, w);
      add_item(CMD_START, RAND_W'($urandom()));
      nsteps = $urandom_range(4, 30);
      for (int i = 0; i < nsteps; i++)
        add_item(($urandom_range(0, 15) == 0) ? CMD_START : CMD_STEP, RAND_W'($urandom()));
      wait_drained();
    end
    stim_done = 1;
    wait_drained();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ randomized_prim_maze_step.f @@
rtl/rpms_pkg.sv
rtl/randomized_prim_maze_step.sv
dv/randomized_prim_maze_step_tb.sv
